/* rtl/plin_pkg.sv */
`default_nettype none
package plin_pkg;

  localparam int POINTS = 16;
  localparam int IDX_W  = $clog2(POINTS);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_ABOVE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [3:0]        point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result_y;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

endpackage
`default_nettype wire

/* rtl/piecewise_linear_interpolator.sv */
// Channel  | Ports                     | Transfer
// input    | start, busy, in_item      | start high while busy low
// result   | out_valid, out_item       | out_valid high, one cycle
// config   | cfg_we, cfg_data          | cfg_we high
// A load or a query on an empty table: the result is registered straight from the transfer.
// A query: the table ring rotates once past the head cell, then a compare state
// follows; out of range or exactly on a point, the result is registered from that
// state. Otherwise a divider load state, 17 divide steps and a result state
// follow before the result is taken.
// busy is high while a query runs. rst_n clears control state only.
// The receiver cannot stall: each result is shown for one cycle.
`default_nettype none
module piecewise_linear_interpolator (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire plin_pkg::in_t  in_item,
  output logic                out_valid,
  output plin_pkg::out_t      out_item,
  input  wire logic           cfg_we,
  input  wire logic [4:0]     cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] state_r;
  logic [4:0] count_r;
  logic [plin_pkg::CNT_W-1:0] n_use;
  logic [plin_pkg::IDX_W-1:0] cnt_r;

  plin_pkg::point_t pts [plin_pkg::POINTS];
  logic wr_go;
  plin_pkg::point_t wr_pt;
  logic shift;

  logic signed [15:0] q_r, min_r, max_r, hity_r, lox_r, loy_r, upx_r, upy_r;
  logic hit_r, hlo_r, hup_r;
  logic signed [15:0] hx, hy;
  logic in_use;

  logic signed [33:0] prod_r;
  logic [16:0] den_r;
  logic [33:0] mag;
  logic div_start, div_done;
  logic [16:0] quot;
  logic signed [16:0] sq, sum;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (count_r > 5'(plin_pkg::POINTS)) begin
      n_use = plin_pkg::CNT_W'(plin_pkg::POINTS);
    end else begin
      n_use = plin_pkg::CNT_W'(count_r);
    end
  end

  assign wr_go = accept && (in_item.mode == plin_pkg::MODE_LOAD)
                 && ({1'b0, in_item.point_index} < 5'(plin_pkg::POINTS));
  assign wr_pt = '{x: in_item.point_x, y: in_item.point_y};
  assign shift = (state_r == S_SCAN);

  for (genvar i = 0; i < plin_pkg::POINTS; i++) begin : g_cell
    plin_cell u_cell (
      .clk   (clk),
      .wr_en (wr_go && (in_item.point_index[plin_pkg::IDX_W-1:0]
                        == plin_pkg::IDX_W'(i))),
      .wr_pt (wr_pt),
      .shift (shift),
      .nb_pt (pts[(i + 1) % plin_pkg::POINTS]),
      .pt_r  (pts[i])
    );
  end

  assign hx     = pts[0].x;
  assign hy     = pts[0].y;
  assign in_use = ({1'b0, cnt_r} < n_use);

  assign mag = prod_r[33] ? 34'(-prod_r) : prod_r;
  assign div_start = (state_r == S_DIV);
  assign sq  = prod_r[33] ? -$signed(quot) : $signed(quot);
  assign sum = 17'(loy_r) + sq;

  plin_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (mag),
    .den    (den_r),
    .done_r (div_done),
    .quot   (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
    end else if (cfg_we) begin
      count_r   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      cnt_r     <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_item.mode == plin_pkg::MODE_LOAD) begin
              out_valid <= 1'b1;
              out_item  <= '{result_y: '0, status: plin_pkg::ST_OK};
            end else if (n_use == '0) begin
              out_valid <= 1'b1;
              out_item  <= '{result_y: '0, status: plin_pkg::ST_EMPTY};
            end else begin
              state_r <= S_SCAN;
              cnt_r   <= '0;
            end
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == plin_pkg::IDX_W'(plin_pkg::POINTS - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (q_r < min_r) begin
            out_valid <= 1'b1;
            out_item  <= '{result_y: '0, status: plin_pkg::ST_BELOW};
            state_r   <= S_IDLE;
          end else if (q_r > max_r) begin
            out_valid <= 1'b1;
            out_item  <= '{result_y: '0, status: plin_pkg::ST_ABOVE};
            state_r   <= S_IDLE;
          end else if (hit_r || !hlo_r || !hup_r) begin
            out_valid <= 1'b1;
            out_item  <= '{result_y: hit_r ? hity_r : 16'sd0,
                           status: plin_pkg::ST_OK};
            state_r   <= S_IDLE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            out_item  <= '{result_y: sum[15:0], status: plin_pkg::ST_OK};
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r   <= in_item.query_x;
      hit_r <= 1'b0;
      hlo_r <= 1'b0;
      hup_r <= 1'b0;
    end else if (state_r == S_SCAN && in_use) begin
      if (cnt_r == '0) begin
        min_r <= hx;
        max_r <= hx;
      end else begin
        if (hx < min_r) min_r <= hx;
        if (hx > max_r) max_r <= hx;
      end
      if (hx == q_r && !hit_r) begin
        hit_r  <= 1'b1;
        hity_r <= hy;
      end else if (hx < q_r) begin
        if (!hlo_r || hx > lox_r) begin
          hlo_r <= 1'b1;
          lox_r <= hx;
          loy_r <= hy;
        end
      end else if (hx > q_r) begin
        if (!hup_r || hx < upx_r) begin
          hup_r <= 1'b1;
          upx_r <= hx;
          upy_r <= hy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= (17'(upy_r) - 17'(loy_r)) * (17'(q_r) - 17'(lox_r));
      den_r  <= 17'(upx_r) - 17'(lox_r);
    end
  end

endmodule
`default_nettype wire

/* rtl/plin_cell.sv */
`default_nettype none
module plin_cell (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire plin_pkg::point_t  wr_pt,
  input  wire logic              shift,
  input  wire plin_pkg::point_t  nb_pt,
  output plin_pkg::point_t       pt_r
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_r <= wr_pt;
    end else if (shift) begin
      pt_r <= nb_pt;
    end
  end

endmodule
`default_nettype wire

/* rtl/plin_div.sv */
`default_nettype none
module plin_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [33:0] num,
  input  wire logic [16:0] den,
  output logic             done_r,
  output logic [16:0]      quot
);

  logic [16:0] rem_r, rem_nxt;
  logic [16:0] low_r;
  logic [16:0] den_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [17:0] part;
  logic [17:0] trial;
  logic        qbit;

  assign part  = {rem_r, low_r[16]};
  assign trial = part - {1'b0, den_r};
  assign qbit  = (part >= {1'b0, den_r});
  assign rem_nxt = qbit ? trial[16:0] : part[16:0];
  assign quot  = low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd17;
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[33:17];
      low_r <= num[16:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[15:0], qbit};
    end
  end

endmodule
`default_nettype wire
